[src/bmdc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmdc_pkg
// Types and constants shared by the manufacturer-data classifier modules.
// ----------------------------------------------------------------------------
package bmdc_pkg;

  localparam int unsigned MAX_FIELD_BYTES = 255;
  localparam logic [7:0]  MAX_COUNT       = 8'(MAX_FIELD_BYTES);
  localparam logic [7:0]  BEACON_MIN_LEN  = 8'd25;
  localparam logic [7:0]  SWIFT_MIN_LEN   = 8'd3;

  localparam logic [15:0] CO_CONT         = 16'h004C;
  localparam logic [15:0] CO_SWIFT        = 16'h0006;
  localparam logic [15:0] HDR_PROX_BEACON = 16'h0215;
  localparam logic [15:0] HDR_ALT_BEACON  = 16'hBEAC;
  localparam logic [7:0]  SWIFT_MARKER    = 8'h03;

  localparam logic [7:0]  TYPE_PROX       = 8'h02;
  localparam logic [7:0]  TYPE_TRACKER    = 8'h12;
  localparam logic [7:0]  STATUS_NEARBY   = 8'h19;
  localparam logic [7:0]  STATUS_OFFLINE  = 8'h00;

  localparam logic [3:0]  NOTE_NONE       = 4'd0;
  localparam logic [3:0]  NOTE_OTHER      = 4'd10;
  localparam logic [3:0]  NOTE_SWIFT      = 4'd11;

  localparam logic [1:0]  BK_NONE         = 2'd0;
  localparam logic [1:0]  BK_PROX         = 2'd1;
  localparam logic [1:0]  BK_ALT          = 2'd2;

  localparam logic [1:0]  TRK_NONE        = 2'd0;
  localparam logic [1:0]  TRK_NEARBY      = 2'd1;
  localparam logic [1:0]  TRK_OFFLINE     = 2'd2;
  localparam logic [1:0]  TRK_OTHER       = 2'd3;

  typedef enum logic [1:0] {
    PH_TYPE,
    PH_LEN,
    PH_FIRST,
    PH_REST
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } byte_t;

  typedef struct packed {
    logic        have_company;
    logic [15:0] company_id;
    logic [3:0]  note_code;
    logic [7:0]  other_type;
    logic [1:0]  beacon_kind;
    logic [31:0] beacon_id_prefix;
    logic [15:0] beacon_major;
    logic [15:0] beacon_minor;
    logic [1:0]  tracker_kind;
    logic [7:0]  byte_count;
  } result_t;

  // Everything the parser remembers about the field in progress.
  typedef struct packed {
    logic [7:0]  count;
    logic [15:0] company;
    phase_t      record_phase;
    logic [7:0]  record_type;
    logic [7:0]  record_remaining;
    logic [7:0]  first_payload;
    logic [3:0]  note;
    logic [7:0]  unknown_type;
    logic [1:0]  tracker;
    logic [15:0] header_bytes;
    logic [31:0] id_prefix;
    logic [31:0] major_minor;
  } field_t;

  // One parser step: fire consumes the held byte, close ends the field.
  typedef struct packed {
    logic fire;
    logic close;
  } step_t;

endpackage

[src/bmdc_in_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmdc_in_stage
// Input register that holds one byte until the parser consumes it.
// ----------------------------------------------------------------------------
module bmdc_in_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           byte_valid,
  output logic           byte_ready,
  input  bmdc_pkg::byte_t byte_item,
  input  logic           pop,
  output logic           q_valid,
  output bmdc_pkg::byte_t q_item
);
  import bmdc_pkg::*;

  // The register refills in the same cycle that its byte is consumed.
  assign byte_ready = !q_valid || pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (byte_ready) begin
      q_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && byte_ready) begin
      q_item <= byte_item;
    end
  end

endmodule

[src/bmdc_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmdc_parser
// Field state and its combinational update for one incoming byte.
// ----------------------------------------------------------------------------
module bmdc_parser (
  input  logic            clk,
  input  logic            rst,
  input  bmdc_pkg::step_t step,
  input  logic [7:0]      data_byte,
  output bmdc_pkg::field_t field_next
);
  import bmdc_pkg::*;

  field_t field;

  function automatic logic [3:0] known_code(input logic [7:0] t);
    logic [3:0] k;
    begin
      case (t)
        8'h05:   k = 4'd1;
        8'h07:   k = 4'd2;
        8'h09:   k = 4'd3;
        8'h0A:   k = 4'd4;
        8'h0B:   k = 4'd5;
        8'h0C:   k = 4'd6;
        8'h0D:   k = 4'd7;
        8'h0F:   k = 4'd8;
        8'h10:   k = 4'd9;
        default: k = NOTE_NONE;
      endcase
      return k;
    end
  endfunction

  // Close the current record; fp is its first payload byte.
  function automatic field_t record_done(input field_t s, input logic has_payload,
                                         input logic [7:0] fp);
    field_t     r;
    logic [3:0] k;
    begin
      r = s;
      k = known_code(s.record_type);
      if (k != NOTE_NONE) begin
        r.note = k;
      end else if (s.record_type != TYPE_PROX && s.record_type != TYPE_TRACKER) begin
        if (s.note == NOTE_NONE) begin
          r.note         = NOTE_OTHER;
          r.unknown_type = s.record_type;
        end
      end
      if (s.record_type == TYPE_TRACKER && has_payload && s.tracker == TRK_NONE) begin
        if (fp == STATUS_NEARBY) begin
          r.tracker = TRK_NEARBY;
        end else if (fp == STATUS_OFFLINE) begin
          r.tracker = TRK_OFFLINE;
        end else begin
          r.tracker = TRK_OTHER;
        end
      end
      r.record_phase = PH_TYPE;
      return r;
    end
  endfunction

  always_comb begin
    field_next = field;
    if (field.count < MAX_COUNT) begin
      case (field.count)
        8'd0:    field_next.company = {8'h00, data_byte};
        8'd1:    field_next.company[15:8] = data_byte;
        8'd2:    field_next.header_bytes = {data_byte, 8'h00};
        8'd3:    field_next.header_bytes[7:0] = data_byte;
        default: ;
      endcase

      // Byte 4 lands in the top byte, byte 7 in the bottom one.
      if (field.count inside {[8'd4:8'd7]}) begin
        case (field.count[1:0])
          2'd0:    field_next.id_prefix[31:24] = data_byte;
          2'd1:    field_next.id_prefix[23:16] = data_byte;
          2'd2:    field_next.id_prefix[15:8]  = data_byte;
          default: field_next.id_prefix[7:0]   = data_byte;
        endcase
      end
      if (field.count inside {[8'd20:8'd23]}) begin
        case (field.count[1:0])
          2'd0:    field_next.major_minor[31:24] = data_byte;
          2'd1:    field_next.major_minor[23:16] = data_byte;
          2'd2:    field_next.major_minor[15:8]  = data_byte;
          default: field_next.major_minor[7:0]   = data_byte;
        endcase
      end

      if (field.count >= 8'd2 && field.company == CO_CONT) begin
        case (field.record_phase)
          PH_TYPE: begin
            field_next.record_type  = data_byte;
            field_next.record_phase = PH_LEN;
          end
          PH_LEN: begin
            field_next.record_remaining = data_byte;
            if (data_byte == 8'h00) begin
              field_next = record_done(field_next, 1'b0, field.first_payload);
            end else begin
              field_next.record_phase = PH_FIRST;
            end
          end
          PH_FIRST: begin
            field_next.first_payload    = data_byte;
            field_next.record_remaining = field.record_remaining - 8'd1;
            if (field.record_remaining == 8'd1) begin
              field_next = record_done(field_next, 1'b1, data_byte);
            end else begin
              field_next.record_phase = PH_REST;
            end
          end
          default: begin
            field_next.record_remaining = field.record_remaining - 8'd1;
            if (field.record_remaining == 8'd1) begin
              field_next = record_done(field_next, 1'b1, field.first_payload);
            end
          end
        endcase
      end

      field_next.count = field.count + 8'd1;
    end
  end

  // The field state starts over once the last byte has been taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      field <= '0;
    end else if (step.fire) begin
      if (step.close) begin
        field <= '0;
      end else begin
        field <= field_next;
      end
    end
  end

endmodule

[src/bmdc_result_reg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmdc_result_reg
// Classifies the finished field and holds the result until it is taken.
// ----------------------------------------------------------------------------
module bmdc_result_reg (
  input  logic             clk,
  input  logic             rst,
  input  bmdc_pkg::step_t  step,
  input  bmdc_pkg::field_t field_next,
  output logic             load_ok,
  output logic             result_valid,
  input  logic             result_ready,
  output bmdc_pkg::result_t result_item
);
  import bmdc_pkg::*;

  result_t res;

  always_comb begin
    res            = '0;
    res.byte_count = field_next.count;
    if (field_next.count >= 8'd2) begin
      res.have_company = 1'b1;
      res.company_id   = field_next.company;
      if (field_next.company == CO_CONT) begin
        res.note_code    = field_next.note;
        res.other_type   = (field_next.note == NOTE_OTHER) ? field_next.unknown_type : 8'h00;
        res.tracker_kind = field_next.tracker;
        if (field_next.count >= BEACON_MIN_LEN &&
            field_next.header_bytes == HDR_PROX_BEACON) begin
          res.beacon_kind      = BK_PROX;
          res.beacon_id_prefix = field_next.id_prefix;
        end
      end else if (field_next.company == CO_SWIFT) begin
        if (field_next.count >= SWIFT_MIN_LEN &&
            field_next.header_bytes[15:8] == SWIFT_MARKER) begin
          res.note_code = NOTE_SWIFT;
        end
      end else if (field_next.count >= BEACON_MIN_LEN &&
                   field_next.header_bytes == HDR_ALT_BEACON) begin
        res.beacon_kind      = BK_ALT;
        res.beacon_id_prefix = {16'h0000, field_next.id_prefix[31:16]};
      end
      if (res.beacon_kind != BK_NONE) begin
        res.beacon_major = field_next.major_minor[31:16];
        res.beacon_minor = field_next.major_minor[15:0];
      end
    end
  end

  assign load_ok = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (step.fire && step.close) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step.fire && step.close) begin
      result_item <= res;
    end
  end

endmodule

[src/ble_manufacturer_data_classifier_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ble_manufacturer_data_classifier_top
// Byte-serial classifier for one BLE manufacturer-specific data field.
// ----------------------------------------------------------------------------
// The block takes one byte of the field per clock while byte_ready is high and
// returns one result per field. The byte marked last_byte waits in the input
// register after its transfer, then passes through the parser update into the
// result register once that register has room, and result_valid rises when it
// is loaded. The parser state update is combinational, so bytes may stream
// without gaps, including the first byte of the next field right after
// the last byte of the previous one. Input is held back only while a finished
// result waits in the result register and the next field's last byte needs it.
module ble_manufacturer_data_classifier_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              byte_valid,
  output logic              byte_ready,
  input  bmdc_pkg::byte_t   byte_item,
  output logic              result_valid,
  input  logic              result_ready,
  output bmdc_pkg::result_t result_item
);
  import bmdc_pkg::*;

  logic   q_valid;
  byte_t  q_item;
  logic   load_ok;
  step_t  step;
  field_t field_next;

  // A closing byte may only move on when the result register has room.
  assign step.fire  = q_valid && (!q_item.last_byte || load_ok);
  assign step.close = q_item.last_byte;

  bmdc_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_item  (byte_item),
    .pop        (step.fire),
    .q_valid    (q_valid),
    .q_item     (q_item)
  );

  bmdc_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .data_byte  (q_item.data_byte),
    .field_next (field_next)
  );

  bmdc_result_reg u_result_reg (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .field_next   (field_next),
    .load_ok      (load_ok),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item)
  );

endmodule
